// ===== rtl/fpc_pkg.sv =====
`default_nettype none

package fpc_pkg;

	localparam int NORMAL_FRAC_BITS = 14;

	localparam int CW      = 32;              // input coordinate width
	localparam int DW      = CW + 1;          // corner difference width
	localparam int PW      = 2 * DW;          // product width
	localparam int XW      = PW + 1;          // cross component width
	localparam int MW      = XW - 1;          // cross magnitude width
	localparam int NORM_W  = 31;              // normalized magnitude width
	localparam int SUMW    = 2 * NORM_W + 2;  // sum of squares width
	localparam int LENW    = SUMW / 2;        // square root width
	localparam int SQRT_STEPS = SUMW / 2;
	localparam int NW      = NORMAL_FRAC_BITS + 2;  // normal component width
	localparam int QB      = NORMAL_FRAC_BITS + 1;  // quotient bits
	localparam int NUMW    = NORM_W + NORMAL_FRAC_BITS + 1;
	localparam int ACCW    = NW + CW + 2;     // distance accumulator width
	localparam int DISTW   = 48;
	localparam int PIDXW   = 3;
	localparam int NCORNERS = 8;
	localparam int SLOTW   = 3;
	localparam int CNTW    = 6;

	localparam logic [PIDXW-1:0] PLANE_FAR = 3'd5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPT,
		OP_DIFF,
		OP_CROSS,
		OP_MAG,
		OP_SHR,
		OP_SHL,
		OP_DEGEN,
		OP_SQ,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_DIST,
		OP_ROUND
	} fpc_op_t;

	typedef struct packed {
		fpc_op_t         op;
		logic [CNTW-1:0] idx;
		logic [1:0]      comp;
	} fpc_cmd_t;

	typedef struct packed {
		logic zero;
		logic high;
		logic low;
	} fpc_status_t;

	// Corners a, b, c of each plane, k selects a (0), b (1) or c (2).
	function automatic logic [SLOTW-1:0] plane_corner(input logic [PIDXW-1:0] p,
		input logic [1:0] k);
		logic [3*SLOTW-1:0] row;
		begin
			case (p)
				3'd0: row = {3'd4, 3'd3, 3'd0};
				3'd1: row = {3'd1, 3'd2, 3'd5};
				3'd2: row = {3'd0, 3'd1, 3'd4};
				3'd3: row = {3'd7, 3'd6, 3'd3};
				3'd4: row = {3'd3, 3'd2, 3'd1};
				3'd5: row = {3'd5, 3'd6, 3'd7};
				default: row = '0;
			endcase
			case (k)
				2'd0: plane_corner = row[SLOTW-1:0];
				2'd1: plane_corner = row[2*SLOTW-1:SLOTW];
				2'd2: plane_corner = row[3*SLOTW-1:2*SLOTW];
				default: plane_corner = '0;
			endcase
		end
	endfunction

	// Product order: u1*v2, u2*v1, u2*v0, u0*v2, u0*v1, u1*v0.
	function automatic logic [1:0] cross_u_sel(input logic [CNTW-1:0] k);
		begin
			case (k)
				6'd0: cross_u_sel = 2'd1;
				6'd1: cross_u_sel = 2'd2;
				6'd2: cross_u_sel = 2'd2;
				6'd3: cross_u_sel = 2'd0;
				6'd4: cross_u_sel = 2'd0;
				6'd5: cross_u_sel = 2'd1;
				default: cross_u_sel = 2'd0;
			endcase
		end
	endfunction

	function automatic logic [1:0] cross_v_sel(input logic [CNTW-1:0] k);
		begin
			case (k)
				6'd0: cross_v_sel = 2'd2;
				6'd1: cross_v_sel = 2'd1;
				6'd2: cross_v_sel = 2'd0;
				6'd3: cross_v_sel = 2'd2;
				6'd4: cross_v_sel = 2'd1;
				6'd5: cross_v_sel = 2'd0;
				default: cross_v_sel = 2'd0;
			endcase
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fpc_ram.sv =====
`default_nettype none

module fpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/fpc_ctrl.sv =====
`default_nettype none

module fpc_ctrl
	import fpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              corner_valid,
	output logic                   corner_stall,
	output logic [SLOTW-1:0]       wr_addr,
	output logic [SLOTW-1:0]       rd_addr,
	output fpc_cmd_t               cmd,
	input  wire fpc_status_t       status,
	input  wire logic              out_ready,
	output logic                   emit,
	output logic [PIDXW-1:0]       plane
);

	typedef enum logic [3:0] {
		S_LOAD, S_RD, S_DIFF, S_CROSS, S_MAG, S_NORM, S_SQ,
		S_SQRT, S_DIV, S_DIST, S_ROUND, S_EMIT
	} state_t;

	state_t            state_q;
	logic [CNTW-1:0]   cnt_q;
	logic [1:0]        comp_q;
	logic [PIDXW-1:0]  plane_q;
	logic [SLOTW-1:0]  slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			comp_q  <= '0;
			plane_q <= '0;
			slot_q  <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (corner_valid) begin
						slot_q <= slot_q + 1'b1;
						if (slot_q == SLOTW'(NCORNERS - 1)) begin
							state_q <= S_RD;
							cnt_q   <= '0;
							plane_q <= '0;
						end
					end
				end
				S_RD: begin
					if (cnt_q == CNTW'(3)) begin
						state_q <= S_DIFF;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIFF: begin
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					if (cnt_q == CNTW'(6)) begin
						state_q <= S_MAG;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MAG: begin
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (status.zero) begin
						state_q <= S_EMIT;
					end else if (!status.high && !status.low) begin
						state_q <= S_SQ;
						cnt_q   <= '0;
					end
				end
				S_SQ: begin
					if (cnt_q == CNTW'(3)) begin
						state_q <= S_SQRT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQRT: begin
					if (cnt_q == CNTW'(SQRT_STEPS)) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
						comp_q  <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == CNTW'(QB + 1)) begin
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							state_q <= S_DIST;
						end else begin
							comp_q <= comp_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIST: begin
					if (cnt_q == CNTW'(3)) begin
						state_q <= S_ROUND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROUND: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) begin
						cnt_q <= '0;
						if (plane_q == PLANE_FAR) begin
							state_q <= S_LOAD;
							plane_q <= '0;
						end else begin
							state_q <= S_RD;
							plane_q <= plane_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign corner_stall = (state_q != S_LOAD);
	assign wr_addr      = slot_q;
	assign plane        = plane_q;
	assign emit         = (state_q == S_EMIT) && out_ready;
	assign rd_addr      = plane_corner(plane_q,
		(cnt_q < CNTW'(3)) ? cnt_q[1:0] : 2'd0);

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.idx  = cnt_q;
		cmd.comp = comp_q;
		case (state_q)
			S_RD:    cmd.op = OP_CAPT;
			S_DIFF:  cmd.op = OP_DIFF;
			S_CROSS: cmd.op = OP_CROSS;
			S_MAG:   cmd.op = OP_MAG;
			S_NORM: begin
				if (status.zero) begin
					cmd.op = OP_DEGEN;
				end else if (status.high) begin
					cmd.op = OP_SHR;
				end else if (status.low) begin
					cmd.op = OP_SHL;
				end
			end
			S_SQ:    cmd.op = OP_SQ;
			S_SQRT:  cmd.op = (cnt_q == '0) ? OP_SQRT_INIT : OP_SQRT_STEP;
			S_DIV: begin
				if (cnt_q == '0) begin
					cmd.op = OP_DIV_INIT;
				end else if (cnt_q == CNTW'(QB + 1)) begin
					cmd.op = OP_DIV_DONE;
				end else begin
					cmd.op = OP_DIV_STEP;
				end
			end
			S_DIST:  cmd.op = OP_DIST;
			S_ROUND: cmd.op = OP_ROUND;
			default: cmd.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/fpc_dp.sv =====
`default_nettype none

module fpc_dp
	import fpc_pkg::*;
(
	input  wire logic                clk,
	input  wire fpc_cmd_t            cmd,
	input  wire logic [3*CW-1:0]     rd_data,
	output fpc_status_t              status,
	output logic signed [NW-1:0]     nrm_x,
	output logic signed [NW-1:0]     nrm_y,
	output logic signed [NW-1:0]     nrm_z,
	output logic signed [DISTW-1:0]  distance,
	output logic                     degen
);

	logic signed [CW-1:0]   pt_q   [3][3];
	logic signed [DW-1:0]   u_q    [3];
	logic signed [DW-1:0]   v_q    [3];
	logic signed [PW-1:0]   prod_q;
	logic signed [XW-1:0]   cr_q   [3];
	logic        [MW-1:0]   mag_q  [3];
	logic                   neg_q  [3];
	logic        [SUMW-1:0] sum_q;
	logic        [SUMW-1:0] x_q;
	logic        [SUMW-1:0] res_q;
	logic        [SUMW-1:0] bit_q;
	logic        [LENW-1:0] rem_q;
	logic        [QB-1:0]   numlow_q;
	logic        [QB-1:0]   quo_q;
	logic signed [NW-1:0]   nrm_q  [3];
	logic signed [ACCW-1:0] acc_q;
	logic signed [DISTW-1:0] dist_q;
	logic                   degen_q;

	logic signed [DW-1:0]   mul_a;
	logic signed [DW-1:0]   mul_b;
	logic        [1:0]      sel;
	logic        [MW-1:0]   mag_or;
	logic        [CNTW-1:0] prev;
	logic        [1:0]      pc;
	logic        [SUMW-1:0] trial;
	logic        [NUMW-1:0] num;
	logic        [LENW:0]   dtry;
	logic        [ACCW-1:0] am;
	logic        [ACCW-1:0] ar;

	assign sel    = (cmd.idx[1:0] == 2'd3) ? 2'd0 : cmd.idx[1:0];
	assign prev   = cmd.idx - 1'b1;
	assign pc     = prev[2:1];
	assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

	assign status.zero = (mag_or == '0);
	assign status.high = |mag_or[MW-1:NORM_W];
	assign status.low  = !mag_or[NORM_W-1];

	assign trial = res_q + bit_q;
	assign num   = (NUMW'(mag_q[cmd.comp][NORM_W-1:0]) << NORMAL_FRAC_BITS)
		+ NUMW'(res_q[LENW-1:1]);
	assign dtry  = {rem_q, numlow_q[QB-1]};
	assign am    = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
	assign ar    = (am + (ACCW'(1) << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS;

	// One shared signed multiplier for cross terms, squares and the distance.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_CROSS: begin
				mul_a = u_q[cross_u_sel(cmd.idx)];
				mul_b = v_q[cross_v_sel(cmd.idx)];
			end
			OP_SQ: begin
				mul_a = signed'({{(DW-NORM_W){1'b0}}, mag_q[sel][NORM_W-1:0]});
				mul_b = mul_a;
			end
			OP_DIST: begin
				mul_a = DW'(nrm_q[sel]);
				mul_b = DW'(pt_q[0][sel]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPT: begin
				if (cmd.idx != '0) begin
					pt_q[prev[1:0]][0] <= rd_data[CW-1:0];
					pt_q[prev[1:0]][1] <= rd_data[2*CW-1:CW];
					pt_q[prev[1:0]][2] <= rd_data[3*CW-1:2*CW];
				end
			end
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= DW'(pt_q[0][i]) - DW'(pt_q[1][i]);
					v_q[i] <= DW'(pt_q[0][i]) - DW'(pt_q[2][i]);
				end
			end
			OP_CROSS: begin
				if (cmd.idx < CNTW'(6)) begin
					prod_q <= mul_a * mul_b;
				end
				if (cmd.idx != '0) begin
					if (!prev[0]) begin
						cr_q[pc] <= XW'(prod_q);
					end else begin
						cr_q[pc] <= cr_q[pc] - XW'(prod_q);
					end
				end
			end
			OP_MAG: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= cr_q[i][XW-1] ? MW'(-cr_q[i]) : MW'(cr_q[i]);
					neg_q[i] <= cr_q[i][XW-1];
				end
				degen_q <= 1'b0;
			end
			OP_SHR: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_q[i] >> 1;
				end
			end
			OP_SHL: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_q[i] << 1;
				end
			end
			OP_DEGEN: begin
				for (int i = 0; i < 3; i++) begin
					nrm_q[i] <= '0;
				end
				dist_q  <= '0;
				degen_q <= 1'b1;
			end
			OP_SQ: begin
				if (cmd.idx < CNTW'(3)) begin
					prod_q <= mul_a * mul_b;
				end
				if (cmd.idx != '0) begin
					sum_q <= ((cmd.idx == CNTW'(1)) ? '0 : sum_q) + prod_q[SUMW-1:0];
				end
			end
			OP_SQRT_INIT: begin
				x_q   <= sum_q;
				res_q <= '0;
				bit_q <= SUMW'(1) << (SUMW - 2);
			end
			OP_SQRT_STEP: begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT: begin
				rem_q    <= LENW'(num >> QB);
				numlow_q <= num[QB-1:0];
				quo_q    <= '0;
			end
			OP_DIV_STEP: begin
				if (dtry >= {1'b0, res_q[LENW-1:0]}) begin
					rem_q <= LENW'(dtry - {1'b0, res_q[LENW-1:0]});
					quo_q <= {quo_q[QB-2:0], 1'b1};
				end else begin
					rem_q <= dtry[LENW-1:0];
					quo_q <= {quo_q[QB-2:0], 1'b0};
				end
				numlow_q <= numlow_q << 1;
			end
			OP_DIV_DONE: begin
				nrm_q[cmd.comp] <= neg_q[cmd.comp] ? -signed'({1'b0, quo_q})
					: signed'({1'b0, quo_q});
			end
			OP_DIST: begin
				if (cmd.idx < CNTW'(3)) begin
					prod_q <= mul_a * mul_b;
				end
				if (cmd.idx != '0) begin
					acc_q <= ((cmd.idx == CNTW'(1)) ? '0 : acc_q) + ACCW'(prod_q);
				end
			end
			OP_ROUND: begin
				dist_q <= acc_q[ACCW-1] ? DISTW'(-signed'(ar)) : DISTW'(signed'(ar));
			end
			default: begin
			end
		endcase
	end

	assign nrm_x    = nrm_q[0];
	assign nrm_y    = nrm_q[1];
	assign nrm_z    = nrm_q[2];
	assign distance = dist_q;
	assign degen    = degen_q;

endmodule

`default_nettype wire

// ===== rtl/frustum_planes_from_corners.sv =====
// Frustum plane extraction from eight corner points.
// Corners arrive on the corner channel (corner_valid / corner_stall), one beat
// per corner, in slot order 0 to 7, as signed Q16.16 coordinates. Each corner
// is written straight into its slot of a small corner RAM. The beat carrying
// the eighth corner starts a run that produces six plane beats on the plane
// channel (plane_valid / plane_stall): left, right, down, up, near and far,
// the last one flagged by last_plane.
// Each plane is computed by one shared signed multiplier, a bit-serial
// square root (one setup and 32 steps) and a restoring divider that runs
// once for each normal component. The cross product is normalized one bit
// position per cycle; a degenerate plane skips the square root, division
// and distance steps. While planes are computed, corner_stall stays high.
// A finished plane waits in the output register while the next plane is
// computed; if plane_stall is held, the block parks with the next plane done
// and the payload is held steady. After the sixth plane enters the output
// register the corner channel opens again for the next run.
// Reset (arst_n low) empties the output register and restarts the corner
// count at slot 0.
`default_nettype none

module frustum_planes_from_corners
	import fpc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    corner_valid,
	output logic                         corner_stall,
	input  wire logic signed [CW-1:0]    corner_x,
	input  wire logic signed [CW-1:0]    corner_y,
	input  wire logic signed [CW-1:0]    corner_z,
	output logic                         plane_valid,
	input  wire logic                    plane_stall,
	output logic [PIDXW-1:0]             plane_index,
	output logic signed [NW-1:0]         normal_x,
	output logic signed [NW-1:0]         normal_y,
	output logic signed [NW-1:0]         normal_z,
	output logic signed [DISTW-1:0]      plane_distance,
	output logic                         degenerate,
	output logic                         last_plane
);

	fpc_cmd_t              cmd;
	fpc_status_t           status;
	logic [SLOTW-1:0]      wr_addr;
	logic [SLOTW-1:0]      rd_addr;
	logic [3*CW-1:0]       rd_data;
	logic                  corner_we;
	logic                  out_ready;
	logic                  emit;
	logic [PIDXW-1:0]      plane;
	logic signed [NW-1:0]  nrm_x;
	logic signed [NW-1:0]  nrm_y;
	logic signed [NW-1:0]  nrm_z;
	logic signed [DISTW-1:0] distance;
	logic                  degen;
	logic                  out_valid_q;

	// A corner beat is written straight into its slot.
	assign corner_we = corner_valid && !corner_stall;

	fpc_ram #(
		.WIDTH(3 * CW),
		.DEPTH(NCORNERS)
	) u_corner_ram (
		.clk   (clk),
		.we    (corner_we),
		.waddr (wr_addr),
		.wdata ({corner_z, corner_y, corner_x}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	fpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.corner_valid (corner_valid),
		.corner_stall (corner_stall),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.emit         (emit),
		.plane        (plane)
	);

	fpc_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.rd_data  (rd_data),
		.status   (status),
		.nrm_x    (nrm_x),
		.nrm_y    (nrm_y),
		.nrm_z    (nrm_z),
		.distance (distance),
		.degen    (degen)
	);

	// The output register can take a new plane when it is empty or its
	// current beat leaves in this cycle.
	assign out_ready = !out_valid_q || !plane_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!plane_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload holds no reset; it only loads together with a new beat.
	always_ff @(posedge clk) begin
		if (emit) begin
			plane_index    <= plane;
			normal_x       <= nrm_x;
			normal_y       <= nrm_y;
			normal_z       <= nrm_z;
			plane_distance <= distance;
			degenerate     <= degen;
			last_plane     <= (plane == PLANE_FAR);
		end
	end

	assign plane_valid = out_valid_q;

`ifndef SYNTH
	// A plane is never loaded over a beat that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_ready)
		else $error("plane loaded over a pending beat");

	// The last flag marks the far plane.
	a_last_is_far: assert property (@(posedge clk) disable iff (!arst_n)
		(plane_valid && last_plane) |-> (plane_index == PLANE_FAR))
		else $error("last_plane on a plane other than far");

	// A degenerate plane carries a zero normal and zero distance.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(plane_valid && degenerate) |-> (normal_x == '0 && normal_y == '0
			&& normal_z == '0 && plane_distance == '0))
		else $error("degenerate plane with nonzero fields");

	// No corner is taken while planes are still being produced.
	a_no_corner_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> corner_stall)
		else $error("corner channel open during plane output");
`endif

endmodule

`default_nettype wire

// ===== verif/frustum_planes_from_corners_tb.sv =====
`timescale 1ns / 100ps

module frustum_planes_from_corners_tb;
	import fpc_pkg::*;

	// One plane beat as seen on the output ports.
	typedef struct {
		logic [PIDXW-1:0]        idx;
		logic signed [NW-1:0]    nx;
		logic signed [NW-1:0]    ny;
		logic signed [NW-1:0]    nz;
		logic signed [DISTW-1:0] distance;
		logic                    degen;
		logic                    last;
	} plane_t;

	// One directed corner beat; flat marks a set whose planes are all
	// degenerate, so their expected values are typed in directly.
	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		bit                   flat;
	} corner_row_t;

	localparam int HALF_PERIOD = 4;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
	localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
	localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic corner_valid = 1'b0;
	logic signed [CW-1:0] corner_x = '0;
	logic signed [CW-1:0] corner_y = '0;
	logic signed [CW-1:0] corner_z = '0;
	logic plane_stall = 1'b0;
	logic corner_stall;
	logic plane_valid;
	logic [PIDXW-1:0] plane_index;
	logic signed [NW-1:0] normal_x;
	logic signed [NW-1:0] normal_y;
	logic signed [NW-1:0] normal_z;
	logic signed [DISTW-1:0] plane_distance;
	logic degenerate;
	logic last_plane;

	// Shadow copy of the corner RAM and the slot counter.
	logic signed [CW-1:0] shadow_corner [8][3];
	int shadow_slot = 0;

	plane_t planes_due [$];
	int mismatches = 0;
	int idle_pct = 27;
	int quiet_cycles = 0;
	corner_row_t directed [$];

	frustum_planes_from_corners i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.corner_valid  (corner_valid),
		.corner_stall  (corner_stall),
		.corner_x      (corner_x),
		.corner_y      (corner_y),
		.corner_z      (corner_z),
		.plane_valid   (plane_valid),
		.plane_stall   (plane_stall),
		.plane_index   (plane_index),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.plane_distance(plane_distance),
		.degenerate    (degenerate),
		.last_plane    (last_plane)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Plane p is spanned by corners a, b and c of this table.
	function automatic int plane_pick(int p, int k);
		int picks [6][3];
		begin
			picks = '{'{0, 3, 4}, '{5, 2, 1}, '{4, 1, 0}, '{3, 6, 7}, '{1, 2, 3}, '{7, 6, 5}};
			return picks[p][k];
		end
	endfunction

	// Computes one plane from the shadow corners: exact cross product, a
	// power-of-two scale to 31 bits, floor square root, rounded division and
	// a rounded dot product with corner a.
	function automatic plane_t plane_from_corners(int p);
		logic signed [127:0] ca [3];
		logic signed [127:0] du [3];
		logic signed [127:0] dv [3];
		logic signed [127:0] cr [3];
		logic [127:0] mg [3];
		logic [63:0] m [3];
		logic signed [63:0] nrm [3];
		logic [63:0] sum, len, t, q, dm;
		logic signed [63:0] dot;
		int ml, i, b;
		plane_t r;
		begin
			for (i = 0; i < 3; i++) begin
				ca[i] = shadow_corner[plane_pick(p, 0)][i];
				du[i] = ca[i] - 128'(shadow_corner[plane_pick(p, 1)][i]);
				dv[i] = ca[i] - 128'(shadow_corner[plane_pick(p, 2)][i]);
			end
			cr[0] = du[1] * dv[2] - du[2] * dv[1];
			cr[1] = du[2] * dv[0] - du[0] * dv[2];
			cr[2] = du[0] * dv[1] - du[1] * dv[0];
			ml = 0;
			for (i = 0; i < 3; i++) begin
				mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
				for (b = 0; b < 128; b++)
					if (mg[i][b] && b + 1 > ml)
						ml = b + 1;
			end
			r.idx = PIDXW'(p);
			r.last = (r.idx == PLANE_FAR);
			r.degen = (ml == 0);
			dot = 0;
			for (i = 0; i < 3; i++)
				nrm[i] = 0;
			if (ml != 0) begin
				sum = 0;
				for (i = 0; i < 3; i++) begin
					m[i] = ml > 31 ? 64'(mg[i] >> (ml - 31)) : 64'(mg[i] << (31 - ml));
					sum += m[i] * m[i];
				end
				len = 0;
				for (b = 31; b >= 0; b--) begin
					t = len | (64'd1 << b);
					if (t * t <= sum)
						len = t;
				end
				for (i = 0; i < 3; i++) begin
					q = ((m[i] << NORMAL_FRAC_BITS) + len / 2) / len;
					nrm[i] = cr[i] < 0 ? -$signed(q) : $signed(q);
					dot += nrm[i] * 64'(shadow_corner[plane_pick(p, 0)][i]);
				end
				dm = dot < 0 ? -dot : dot;
				dm = (dm + (64'd1 << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS;
				dot = dot < 0 ? -$signed(dm) : $signed(dm);
			end
			r.nx = nrm[0][NW-1:0];
			r.ny = nrm[1][NW-1:0];
			r.nz = nrm[2][NW-1:0];
			r.distance = dot[DISTW-1:0];
			return r;
		end
	endfunction

	// Stores an accepted corner; the eighth corner of a set queues six planes.
	task automatic take_corner(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input logic signed [CW-1:0] z, input bit flat);
		plane_t r;
		begin
			shadow_corner[shadow_slot][0] = x;
			shadow_corner[shadow_slot][1] = y;
			shadow_corner[shadow_slot][2] = z;
			if (shadow_slot == 7) begin
				for (int p = 0; p < 6; p++) begin
					if (flat) begin
						r.idx = PIDXW'(p);
						r.nx = '0;
						r.ny = '0;
						r.nz = '0;
						r.distance = '0;
						r.degen = 1'b1;
						r.last = (p == 5);
					end else begin
						r = plane_from_corners(p);
					end
					planes_due.push_back(r);
				end
			end
			shadow_slot = (shadow_slot + 1) % 8;
		end
	endtask

	// Presents one corner beat at the falling edge, with random idle cycles
	// first, and holds it until the rising edge that accepts it.
	task automatic send_corner(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input logic signed [CW-1:0] z, input bit flat);
		begin
			@(negedge clk);
			while ($urandom_range(99) < idle_pct) begin
				corner_valid = 1'b0;
				@(negedge clk);
			end
			corner_valid = 1'b1;
			corner_x = x;
			corner_y = y;
			corner_z = z;
			do @(posedge clk); while (corner_stall);
			take_corner(x, y, z, flat);
		end
	endtask

	// A random coordinate whose magnitude is, three times in four, cut down by a
	// random shift, so that the cross product covers both scaling directions.
	function automatic logic signed [CW-1:0] rand_coord();
		logic signed [CW-1:0] v;
		begin
			v = $urandom;
			if ($urandom_range(3) != 0)
				v = v >>> $urandom_range(31);
			return v;
		end
	endfunction

	// The receiver stalls at random, driven at the falling edge.
	always @(negedge clk)
		plane_stall = arst_n && ($urandom_range(99) < idle_pct);

	// Compare every accepted plane beat with the oldest expected plane.
	always @(posedge clk) begin
		plane_t want;
		if (arst_n && plane_valid && !plane_stall) begin
			if (planes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected plane beat, index %0d", plane_index);
			end else begin
				want = planes_due.pop_front();
				if (plane_index !== want.idx || normal_x !== want.nx || normal_y !== want.ny ||
					normal_z !== want.nz || plane_distance !== want.distance ||
					degenerate !== want.degen || last_plane !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("plane mismatch: exp idx %0d n %0d %0d %0d d %0d dg %b l %b, ",
							"got idx %0d n %0d %0d %0d d %0d dg %b l %b",
							want.idx, want.nx, want.ny, want.nz, want.distance, want.degen,
							want.last, plane_index, normal_x, normal_y, normal_z,
							plane_distance, degenerate, last_plane);
				end
			end
		end
	end

	// Watchdog: too long without any beat on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (corner_valid && !corner_stall) || (plane_valid && !plane_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("frustum_planes_from_corners verification failed");
			$finish;
		end
	end

	initial begin
		corner_row_t row;
		logic signed [CW-1:0] px, py, pz;
		int kind;
		// Set one: all eight corners at the same point, every plane degenerate.
		for (int i = 0; i < 8; i++)
			directed.push_back('{CMAX, CMIN, 32'sd0, 1'b1});
		// Set two: the cube from -1 to 1 on each axis, the ordinary frustum shape.
		for (int i = 0; i < 8; i++)
			directed.push_back('{(i & 1) ? ONE : -ONE, (i & 2) ? ONE : -ONE,
				(i & 4) ? ONE : -ONE, 1'b0});
		// Set three: a cube at the coordinate extremes, widest differences.
		for (int i = 0; i < 8; i++)
			directed.push_back('{(i & 1) ? CMAX : CMIN, (i & 2) ? CMIN : CMAX,
				(i & 4) ? CMAX : CMIN, 1'b0});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			row = directed[i];
			send_corner(row.x, row.y, row.z, row.flat);
		end

		for (int set = 0; set < 11; set++) begin
			// A stretch with no idling on either side.
			idle_pct = (set >= 4 && set < 7) ? 0 : 27;
			// Once, hold the corner channel until every plane has arrived.
			if (set == 8) begin
				@(negedge clk);
				corner_valid = 1'b0;
				while (planes_due.size() != 0)
					@(posedge clk);
			end
			kind = $urandom_range(5);
			px = rand_coord();
			py = rand_coord();
			pz = rand_coord();
			for (int i = 0; i < 8; i++) begin
				if (kind == 0)
					send_corner(px, py, pz, 1'b0);          // collinear set
				else if (kind == 1 && (i & 1))
					send_corner(px, py, pz, 1'b0);          // some planes collapse
				else
					send_corner(rand_coord(), rand_coord(), rand_coord(), 1'b0);
			end
		end

		@(negedge clk);
		corner_valid = 1'b0;
		while (planes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && planes_due.size() == 0)
			$display("frustum_planes_from_corners verification clean");
		else
			$display("frustum_planes_from_corners verification failed");
		$finish;
	end

endmodule
